// ===== rtl/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and codes of the three-class priority queue
// Word formats of both channels, the command that passes from the front
// end to the back end, and the status, class and operation codes.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int NUM_CLASSES = 3;

  // Depth of the command queue between the front and the back end.
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int QPTR_W          = $clog2(CMD_QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);

  // Operation codes.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SERVE   = 1'b1;

  // Class codes.
  localparam logic [1:0] CLS_NORMAL       = 2'd0;
  localparam logic [1:0] CLS_PREFERENTIAL = 2'd1;
  localparam logic [1:0] CLS_URGENT       = 2'd2;
  localparam logic [1:0] CLS_OVERRANGE    = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_ENQUEUED = 3'd0;
  localparam logic [2:0] ST_SERVED   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BAD_AGE  = 3'd4;

  typedef struct packed {
    logic        op;
    logic [1:0]  queue_class;
    logic [31:0] entry_tag;
    logic [7:0]  entry_age;
    logic [31:0] arrival_time;
    logic [31:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  served_class;
    logic [31:0] served_tag;
    logic [7:0]  served_age;
    logic [31:0] served_arrival;
    logic [31:0] service_time;
  } out_word_t;

  // Command kinds after classification by the front end.
  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_SERVE,
    CMD_BAD_AGE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  cls;
    logic [31:0] tag;
    logic [7:0]  age;
    logic [31:0] arrival;
    logic [31:0] now;
  } cmd_t;

endpackage

// ===== rtl/tcpq_front.sv =====
// ----------------------------------------------------------------------------
// tcpq_front: input acceptance, classification and command queue
// Takes input words, sorts them into enqueue, serve and bad-age commands,
// and holds them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module tcpq_front
  import tcpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  cmd_t              q [CMD_QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign in_stall  = (count == QCNT_W'(CMD_QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = q[rd_ptr];

  // Class three folds into urgent; a zero age on an enqueue is caught here so
  // the back end never looks at the store for it.
  always_comb begin
    new_cmd.cls     = (in_word.queue_class == CLS_OVERRANGE) ? CLS_URGENT
                                                             : in_word.queue_class;
    new_cmd.tag     = in_word.entry_tag;
    new_cmd.age     = in_word.entry_age;
    new_cmd.arrival = in_word.arrival_time;
    new_cmd.now     = in_word.now_time;
    if (in_word.op == OP_SERVE) begin
      new_cmd.kind = CMD_SERVE;
    end else if (in_word.entry_age == 8'd0) begin
      new_cmd.kind = CMD_BAD_AGE;
    end else begin
      new_cmd.kind = CMD_ENQ;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tcpq_back.sv =====
// ----------------------------------------------------------------------------
// tcpq_back: queue pointers, entry memory and result register
// Carries out one command at a time against the three class queues and
// places its result word in the output register.
// ----------------------------------------------------------------------------
module tcpq_back
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [7:0]  age;
    logic [31:0] arrival;
  } slot_t;

  state_t            state;
  logic [IDX_W-1:0]  head [NUM_CLASSES];
  logic [IDX_W-1:0]  tail [NUM_CLASSES];
  logic [CNT_W-1:0]  fill [NUM_CLASSES];
  slot_t             mem  [MEM_DEPTH];
  slot_t             rd_slot;
  logic [1:0]        serve_cls;
  logic [31:0]       serve_now;

  logic              out_free;
  logic              enq_full;
  logic              mem_we;
  logic              mem_re;
  logic              srv_hit;
  logic [1:0]        srv_cls;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  out_word_t         idle_word;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    next_slot = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    out_free = !out_valid || !out_stall;
    cmd_take = (state == S_IDLE) && cmd_valid && out_free;
    enq_full = (fill[cmd.cls] == CNT_W'(QUEUE_DEPTH));

    // Strict priority: urgent, then preferential, then normal.
    srv_hit = 1'b1;
    if (fill[CLS_URGENT] != '0) begin
      srv_cls = CLS_URGENT;
    end else if (fill[CLS_PREFERENTIAL] != '0) begin
      srv_cls = CLS_PREFERENTIAL;
    end else begin
      srv_cls = CLS_NORMAL;
      srv_hit = (fill[CLS_NORMAL] != '0);
    end

    mem_we  = cmd_take && (cmd.kind == CMD_ENQ) && !enq_full;
    mem_re  = cmd_take && (cmd.kind == CMD_SERVE) && srv_hit;
    wr_addr = ADDR_W'(QUEUE_DEPTH) * ADDR_W'(cmd.cls) + ADDR_W'(tail[cmd.cls]);
    rd_addr = ADDR_W'(QUEUE_DEPTH) * ADDR_W'(srv_cls) + ADDR_W'(head[srv_cls]);

    // Result of every command that finishes without a memory read.
    idle_word = '0;
    case (cmd.kind)
      CMD_BAD_AGE: idle_word.status = ST_BAD_AGE;
      CMD_ENQ:     idle_word.status = enq_full ? ST_FULL : ST_ENQUEUED;
      CMD_SERVE:   idle_word.status = ST_EMPTY;
      default:     idle_word.status = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{tag: cmd.tag, age: cmd.age, arrival: cmd.arrival};
    end
    if (mem_re) begin
      rd_slot <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        fill[c] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_take && !mem_re) begin
            if (mem_we) begin
              tail[cmd.cls] <= next_slot(tail[cmd.cls]);
              fill[cmd.cls] <= fill[cmd.cls] + 1'b1;
            end
            out_valid <= 1'b1;
            out_word  <= idle_word;
          end else begin
            // The result register empties once its word is taken.
            if (out_valid && !out_stall) begin
              out_valid <= 1'b0;
            end
            if (mem_re) begin
              head[srv_cls] <= next_slot(head[srv_cls]);
              fill[srv_cls] <= fill[srv_cls] - 1'b1;
              serve_cls     <= srv_cls;
              serve_now     <= cmd.now;
              state         <= S_READ;
            end
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_word  <= '{status:         ST_SERVED,
                         served_class:   serve_cls,
                         served_tag:     rd_slot.tag,
                         served_age:     rd_slot.age,
                         served_arrival: rd_slot.arrival,
                         service_time:   serve_now};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No class ever holds more entries than its queue has slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill[CLS_NORMAL] <= CNT_W'(QUEUE_DEPTH) &&
    fill[CLS_PREFERENTIAL] <= CNT_W'(QUEUE_DEPTH) &&
    fill[CLS_URGENT] <= CNT_W'(QUEUE_DEPTH))
    else $error("class fill count beyond queue depth");

  // A serve read only starts once the previous result has left.
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid)
    else $error("serve read while result register occupied");

  // The read cycle always ends in a served result word.
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (out_valid && out_word.status == ST_SERVED &&
                           state == S_IDLE))
    else $error("serve read did not produce a served word");

  // An entry is only written into a class that has room.
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (fill[cmd.cls] < CNT_W'(QUEUE_DEPTH) && cmd.cls != CLS_OVERRANGE))
    else $error("entry written into a full or invalid class");

endmodule

// ===== rtl/three_class_priority_queue.sv =====
// ----------------------------------------------------------------------------
// three_class_priority_queue: strict-priority queue with three FIFO classes
// Top level joining the classifying front end and the queue back end.
// ----------------------------------------------------------------------------
// The block keeps three FIFO queues of QUEUE_DEPTH entries each (normal,
// preferential and urgent). Each input word either enqueues an entry (tag,
// age, arrival time) into a class or serves the oldest entry of the highest
// non-empty class, and every input word yields exactly one result word. A
// zero age is rejected before fullness is checked, class three is treated
// as urgent, and a serve with all queues empty reports so and changes
// nothing. The front end accepts and classifies words into a two-word
// command queue, so the input keeps flowing while the back end works or the
// output is stalled, until that queue fills. In the back end, enqueues,
// rejected words and empty serves need no memory read; a serve that finds
// an entry also passes a read state, as the entry memory (three times
// QUEUE_DEPTH words) has a registered read port, and blocks new commands
// meanwhile. Enqueues run at one word per cycle unless the output stalls.
// Entry memory needs no clearing at reset; only written entries are read.
// ----------------------------------------------------------------------------
module three_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  // Front end: accepts words and queues classified commands.
  tcpq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // Back end: owns the class pointers, the entry memory and the result.
  tcpq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
